FILE: sv/mbic_pkg.sv
// ----------------------------------------------------------------------------
// mbic_pkg
// Types and constants shared by the mapper bank and IRQ controller.
// ----------------------------------------------------------------------------
package mbic_pkg;

	typedef struct packed {
		logic        mode;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
	} in_item_t;

	typedef struct packed {
		logic       irq_line;
		logic [2:0] event_kind;
		logic [2:0] event_slot;
		logic [7:0] event_value;
		logic [7:0] sound_register;
	} out_item_t;

	// decoded write and tick actions on block state
	typedef struct packed {
		logic       tick;
		logic       sound_sel_wr;
		logic       reload_wr;
		logic       ctrl_wr;
		logic       ack_wr;
		logic [7:0] data;
	} state_cmd_t;

	localparam logic       MODE_WRITE = 1'b0;
	localparam logic       MODE_TICK  = 1'b1;

	localparam logic [2:0] EV_NONE  = 3'd0;
	localparam logic [2:0] EV_PRG   = 3'd1;
	localparam logic [2:0] EV_CHR   = 3'd2;
	localparam logic [2:0] EV_MIRR  = 3'd3;
	localparam logic [2:0] EV_SOUND = 3'd4;
	localparam logic [2:0] EV_IRQ   = 3'd5;

	localparam logic [2:0] IRQ_SLOT_RELOAD = 3'd0;
	localparam logic [2:0] IRQ_SLOT_CTRL   = 3'd1;
	localparam logic [2:0] IRQ_SLOT_ACK    = 3'd2;

	localparam logic [1:0] CFG_VARIANT   = 2'd0;
	localparam logic [1:0] CFG_PRG_LIMIT = 2'd1;
	localparam logic [1:0] CFG_CHR_LIMIT = 2'd2;

	localparam logic [15:0] MASK_A   = 16'hF020;
	localparam logic [15:0] MASK_B   = 16'hF000;

	localparam logic [15:0] A_PRG0   = 16'h8000;
	localparam logic [15:0] A_PRG1   = 16'h8001;
	localparam logic [15:0] A_PRG2   = 16'h9000;
	localparam logic [15:0] A_SNDSEL = 16'h9001;
	localparam logic [15:0] A_SNDDAT = 16'h9021;
	localparam logic [15:0] A_CHR0   = 16'hA000;
	localparam logic [15:0] A_CHR1   = 16'hA001;
	localparam logic [15:0] A_CHR2   = 16'hB000;
	localparam logic [15:0] A_CHR3   = 16'hB001;
	localparam logic [15:0] A_CHR4   = 16'hC000;
	localparam logic [15:0] A_CHR5   = 16'hC001;
	localparam logic [15:0] A_CHR6   = 16'hD000;
	localparam logic [15:0] A_CHR7   = 16'hD001;
	localparam logic [15:0] A_MIRR   = 16'hE000;
	localparam logic [15:0] A_RELOAD = 16'hE001;
	localparam logic [15:0] A_CTRL   = 16'hF000;
	localparam logic [15:0] A_ACK    = 16'hF001;

	localparam logic [8:0] PRESCALE_PERIOD = 9'd338;
	localparam logic [8:0] PRESCALE_STEP   = 9'd3;

	function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] lim);
		return (v > lim) ? (v & lim) : v;
	endfunction

endpackage

FILE: sv/mbic_decode.sv
// ----------------------------------------------------------------------------
// mbic_decode
// Folds a write address per board variant and decodes it into an event and
// state commands.
// ----------------------------------------------------------------------------
module mbic_decode (
	input  mbic_pkg::in_item_t   item,
	input  logic                 board_variant,
	input  logic [7:0]           prg_bank_limit,
	input  logic [7:0]           chr_bank_limit,
	output logic [2:0]           event_kind,
	output logic [2:0]           event_slot,
	output logic [7:0]           event_value,
	output mbic_pkg::state_cmd_t cmd
);
	import mbic_pkg::*;

	logic [15:0] folded;
	logic [3:0]  chr_hi;
	logic [7:0]  d;

	assign d      = item.bus_data;
	assign chr_hi = folded[15:12] - 4'hA;

	always_comb begin
		if (board_variant == 1'b0) begin
			folded = (item.bus_address & MASK_A) |
				{14'd0, item.bus_address[3], item.bus_address[4]};
		end else begin
			folded = (item.bus_address & MASK_B) |
				{14'd0, item.bus_address[4], item.bus_address[3]};
		end
	end

	always_comb begin
		event_kind       = EV_NONE;
		event_slot       = 3'd0;
		event_value      = 8'd0;
		cmd              = '0;
		cmd.data         = d;
		cmd.tick         = (item.mode == MODE_TICK);
		if (item.mode == MODE_WRITE) begin
			unique case (folded)
				A_PRG0: begin
					event_kind  = EV_PRG;
					event_slot  = 3'd0;
					event_value = limit_bank(d, prg_bank_limit);
				end
				A_PRG1: begin
					event_kind  = EV_PRG;
					event_slot  = 3'd1;
					event_value = limit_bank(d, prg_bank_limit);
				end
				A_PRG2: begin
					event_kind  = EV_PRG;
					event_slot  = 3'd2;
					event_value = limit_bank(d, prg_bank_limit);
				end
				A_SNDSEL: cmd.sound_sel_wr = 1'b1;
				A_SNDDAT: begin
					event_kind  = EV_SOUND;
					event_value = d;
				end
				A_CHR0, A_CHR1, A_CHR2, A_CHR3,
				A_CHR4, A_CHR5, A_CHR6, A_CHR7: begin
					event_kind  = EV_CHR;
					event_slot  = {chr_hi[1:0], folded[0]};
					event_value = limit_bank(d, chr_bank_limit);
				end
				A_MIRR: begin
					event_kind  = EV_MIRR;
					event_value = {6'd0, d[1:0]};
				end
				A_RELOAD: begin
					event_kind    = EV_IRQ;
					event_slot    = IRQ_SLOT_RELOAD;
					event_value   = d;
					cmd.reload_wr = 1'b1;
				end
				A_CTRL: begin
					event_kind  = EV_IRQ;
					event_slot  = IRQ_SLOT_CTRL;
					event_value = d;
					cmd.ctrl_wr = 1'b1;
				end
				A_ACK: begin
					event_kind  = EV_IRQ;
					event_slot  = IRQ_SLOT_ACK;
					event_value = d;
					cmd.ack_wr  = 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: sv/mbic_state.sv
// ----------------------------------------------------------------------------
// mbic_state
// Sound register select, IRQ registers, prescaler and cycle counter.
// State advances once per accepted beat leaving the input stage.
// ----------------------------------------------------------------------------
module mbic_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  mbic_pkg::state_cmd_t cmd,
	output logic                 irq_next,
	output logic [7:0]           sound_next
);
	import mbic_pkg::*;

	logic [7:0] sound_sel_q, reload_q, counter_q;
	logic       irq_en_q, cycle_mode_q, ack_en_q, delay_q, pending_q;
	logic [8:0] acc_q;

	logic [7:0] sound_sel_d, reload_d, counter_d;
	logic       irq_en_d, cycle_mode_d, ack_en_d, delay_d, pending_d;
	logic [8:0] acc_d;

	always_comb begin
		sound_sel_d  = sound_sel_q;
		reload_d     = reload_q;
		counter_d    = counter_q;
		irq_en_d     = irq_en_q;
		cycle_mode_d = cycle_mode_q;
		ack_en_d     = ack_en_q;
		delay_d      = delay_q;
		pending_d    = pending_q;
		acc_d        = acc_q;
		if (cmd.tick) begin
			if (delay_q) begin
				delay_d   = 1'b0;
				pending_d = 1'b1;
			end
			if (irq_en_q) begin
				if (!cycle_mode_q && (acc_q < PRESCALE_PERIOD)) begin
					acc_d = acc_q + PRESCALE_STEP;
				end else begin
					if (!cycle_mode_q)
						acc_d = acc_q - PRESCALE_PERIOD;
					if (counter_q != 8'hFF) begin
						counter_d = counter_q + 8'd1;
					end else begin
						counter_d = reload_q;
						delay_d   = 1'b1;
					end
				end
			end
		end
		if (cmd.sound_sel_wr)
			sound_sel_d = cmd.data;
		if (cmd.reload_wr)
			reload_d = cmd.data;
		if (cmd.ctrl_wr) begin
			ack_en_d     = cmd.data[0];
			irq_en_d     = cmd.data[1];
			cycle_mode_d = cmd.data[2];
			if (cmd.data[1]) begin
				acc_d     = '0;
				counter_d = reload_q;
			end
			pending_d = 1'b0;
		end
		if (cmd.ack_wr) begin
			irq_en_d  = ack_en_q;
			pending_d = 1'b0;
		end
	end

	assign irq_next   = pending_d;
	assign sound_next = sound_sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_sel_q  <= '0;
			reload_q     <= '0;
			counter_q    <= '0;
			irq_en_q     <= 1'b0;
			cycle_mode_q <= 1'b0;
			ack_en_q     <= 1'b0;
			delay_q      <= 1'b0;
			pending_q    <= 1'b0;
			acc_q        <= '0;
		end else if (en) begin
			sound_sel_q  <= sound_sel_d;
			reload_q     <= reload_d;
			counter_q    <= counter_d;
			irq_en_q     <= irq_en_d;
			cycle_mode_q <= cycle_mode_d;
			ack_en_q     <= ack_en_d;
			delay_q      <= delay_d;
			pending_q    <= pending_d;
			acc_q        <= acc_d;
		end
	end

endmodule

FILE: sv/mapper_bank_and_irq_controller.sv
// ----------------------------------------------------------------------------
// mapper_bank_and_irq_controller
// Cartridge mapper bank decode with a cycle driven IRQ counter.
//
//   channel  | direction | handshake                  | payload
//   item     | in        | item_valid / item_ready     | in_item_t
//   result   | out       | result_valid / result_ready | out_item_t
//   cfg      | in        | cfg_we (no wait)            | cfg_index, cfg_data
//
// One beat per cycle while the result side accepts; an item passes the input
// register, then decode and state update into the result register.
// A stalled result holds the input register; the result register and input
// register together let a new beat in while a result waits.
// Reset clears all state and sets both bank limits to 255.
// ----------------------------------------------------------------------------
module mapper_bank_and_irq_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mbic_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output mbic_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import mbic_pkg::*;

	logic       variant_q;
	logic [7:0] prg_limit_q, chr_limit_q;

	logic       valid_s1;
	in_item_t   item_s1;
	logic       adv;

	logic       [2:0] kind, slot;
	logic       [7:0] value, sound_next;
	logic       irq_next;
	state_cmd_t cmd;

	assign adv        = valid_s1 && (!result_valid || result_ready);
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q   <= 1'b0;
			prg_limit_q <= 8'hFF;
			chr_limit_q <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_VARIANT:   variant_q   <= cfg_data[0];
				CFG_PRG_LIMIT: prg_limit_q <= cfg_data;
				CFG_CHR_LIMIT: chr_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	mbic_decode u_decode (
		.item           (item_s1),
		.board_variant  (variant_q),
		.prg_bank_limit (prg_limit_q),
		.chr_bank_limit (chr_limit_q),
		.event_kind     (kind),
		.event_slot     (slot),
		.event_value    (value),
		.cmd            (cmd)
	);

	mbic_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.cmd        (cmd),
		.irq_next   (irq_next),
		.sound_next (sound_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.irq_line       <= irq_next;
			result.event_kind     <= kind;
			result.event_slot     <= slot;
			result.event_value    <= value;
			result.sound_register <= sound_next;
		end
	end

endmodule

FILE: sv/mbic_checker.sv
// ----------------------------------------------------------------------------
// mbic_checker
// Port level checks on the result channel of the mapper controller.
// ----------------------------------------------------------------------------
module mbic_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                result_valid,
	input logic                result_ready,
	input mbic_pkg::out_item_t result
);
	import mbic_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat dropped or changed while stalled");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.event_kind <= EV_IRQ))
		else $error("event kind out of range");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_kind == EV_NONE) |->
		(result.event_slot == 3'd0) && (result.event_value == 8'd0))
		else $error("empty event carries slot or value");

	a_prg_slot: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_kind == EV_PRG) |-> (result.event_slot <= 3'd2))
		else $error("program slot out of range");

	a_mirr: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.event_kind == EV_MIRR) |->
		(result.event_value[7:2] == 6'd0) && (result.event_slot == 3'd0))
		else $error("mirroring code wider than two bits");

endmodule

bind mapper_bank_and_irq_controller mbic_checker u_mbic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

FILE: dv/mapper_shadow_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mapper_shadow_pkg
// Shadow copy of the mapper's bank decode and IRQ counter. Every accepted
// input beat is run through it to form the expected result. Results from the
// block are compared with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
package mapper_shadow_pkg;

	import mbic_pkg::*;

	class mapper_shadow;
		bit         variant;
		logic [7:0] prg_lim;
		logic [7:0] chr_lim;

		logic [7:0] snd_sel;
		logic [7:0] reload;
		logic [7:0] counter;
		logic [8:0] presc;
		logic       irq_en;
		logic       cyc_mode;
		logic       ack_en;
		logic       delay;
		logic       pending;

		out_item_t  due[$];
		int         checked;
		int         mismatches;
		int         strays;
		int         irq_high;
		int         shown;

		function new();
			variant    = 1'b0;
			prg_lim    = 8'hFF;
			chr_lim    = 8'hFF;
			snd_sel    = '0;
			reload     = '0;
			counter    = '0;
			presc      = '0;
			irq_en     = 1'b0;
			cyc_mode   = 1'b0;
			ack_en     = 1'b0;
			delay      = 1'b0;
			pending    = 1'b0;
			checked    = 0;
			mismatches = 0;
			strays     = 0;
			irq_high   = 0;
			shown      = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_VARIANT:   variant = val[0];
				CFG_PRG_LIMIT: prg_lim = val;
				CFG_CHR_LIMIT: chr_lim = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] clamp(logic [7:0] v, logic [7:0] lim);
			if (v > lim)
				return v & lim;
			return v;
		endfunction

		function logic [15:0] fold(logic [15:0] a);
			if (!variant)
				return (a & MASK_A) | {14'd0, a[3], a[4]};
			return (a & MASK_B) | {14'd0, a[4], a[3]};
		endfunction

		function void cpu_cycle();
			if (delay) begin
				delay   = 1'b0;
				pending = 1'b1;
			end
			if (!irq_en)
				return;
			if (!cyc_mode) begin
				if (presc < PRESCALE_PERIOD) begin
					presc = presc + PRESCALE_STEP;
					return;
				end
				presc = presc - PRESCALE_PERIOD;
			end
			if (counter != 8'hFF) begin
				counter = counter + 8'd1;
			end else begin
				counter = reload;
				delay   = 1'b1;
			end
		endfunction

		function void note_beat(in_item_t it);
			out_item_t  r;
			logic [15:0] f;
			logic [7:0]  d;
			logic [3:0]  row;
			r = '0;
			d = it.bus_data;
			if (it.mode == MODE_TICK) begin
				cpu_cycle();
			end else begin
				f = fold(it.bus_address);
				case (f)
					A_PRG0: begin
						r.event_kind  = EV_PRG;
						r.event_slot  = 3'd0;
						r.event_value = clamp(d, prg_lim);
					end
					A_PRG1: begin
						r.event_kind  = EV_PRG;
						r.event_slot  = 3'd1;
						r.event_value = clamp(d, prg_lim);
					end
					A_PRG2: begin
						r.event_kind  = EV_PRG;
						r.event_slot  = 3'd2;
						r.event_value = clamp(d, prg_lim);
					end
					A_SNDSEL: snd_sel = d;
					A_SNDDAT: begin
						r.event_kind  = EV_SOUND;
						r.event_value = d;
					end
					A_CHR0, A_CHR1, A_CHR2, A_CHR3, A_CHR4, A_CHR5, A_CHR6, A_CHR7: begin
						row           = f[15:12] - 4'hA;
						r.event_kind  = EV_CHR;
						r.event_slot  = {row[1:0], f[0]};
						r.event_value = clamp(d, chr_lim);
					end
					A_MIRR: begin
						r.event_kind  = EV_MIRR;
						r.event_value = {6'd0, d[1:0]};
					end
					A_RELOAD: begin
						r.event_kind  = EV_IRQ;
						r.event_slot  = IRQ_SLOT_RELOAD;
						r.event_value = d;
						reload        = d;
					end
					A_CTRL: begin
						r.event_kind  = EV_IRQ;
						r.event_slot  = IRQ_SLOT_CTRL;
						r.event_value = d;
						ack_en        = d[0];
						irq_en        = d[1];
						cyc_mode      = d[2];
						if (irq_en) begin
							presc   = '0;
							counter = reload;
						end
						pending = 1'b0;
					end
					A_ACK: begin
						r.event_kind  = EV_IRQ;
						r.event_slot  = IRQ_SLOT_ACK;
						r.event_value = d;
						irq_en        = ack_en;
						pending       = 1'b0;
					end
					default: ;
				endcase
			end
			r.irq_line       = pending;
			r.sound_register = snd_sel;
			due.push_back(r);
		endfunction

		function void check_beat(out_item_t got);
			out_item_t want;
			checked++;
			if (got.irq_line === 1'b1)
				irq_high++;
			if (due.size() == 0) begin
				strays++;
				if (shown < 10)
					$display("%0t: result with nothing expected: irq=%0d kind=%0d slot=%0d val=%02h snd=%02h",
						$time, got.irq_line, got.event_kind, got.event_slot, got.event_value,
						got.sound_register);
				shown++;
				return;
			end
			want = due.pop_front();
			if (got.irq_line !== want.irq_line || got.event_kind !== want.event_kind ||
				got.event_slot !== want.event_slot || got.event_value !== want.event_value ||
				got.sound_register !== want.sound_register) begin
				mismatches++;
				if (shown < 10) begin
					$display("%0t: mismatch, exp irq=%0d kind=%0d slot=%0d val=%02h snd=%02h",
						$time, want.irq_line, want.event_kind, want.event_slot, want.event_value,
						want.sound_register);
					$display("%0t:           got irq=%0d kind=%0d slot=%0d val=%02h snd=%02h",
						$time, got.irq_line, got.event_kind, got.event_slot, got.event_value,
						got.sound_register);
				end
				shown++;
			end
		endfunction

		function int outstanding();
			return due.size();
		endfunction
	endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the mapper bank and IRQ controller. A short directed run hits
// every decoded register, bank masking and an IRQ overflow; random runs then
// mix IRQ counter sequences with bank writes and address noise over several
// board settings. Both channels idle at random; the receiver holds off once to
// fill the block; the sender drains at each board change and once mid-run.
// ----------------------------------------------------------------------------
module tb_top;

	import mbic_pkg::*;
	import mapper_shadow_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int RUN_BEATS   = 125;
	localparam int HOLD_CYCLES = 200;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	in_item_t    item;
	logic        result_valid;
	logic        result_ready;
	out_item_t   result;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;

	mapper_shadow sb;
	in_item_t     plan[$];
	bit           cur_variant;
	bit           quiet;
	bit           hold_req;
	int           idle_cycles;
	int           beats_sent;

	mapper_bank_and_irq_controller dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_ready <= 1'b1;
				hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial idle_cycles = 0;

	always @(posedge clk) begin
		if (item_valid && item_ready)
			sb.note_beat(item);
		if (result_valid && result_ready)
			sb.check_beat(result);
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) @(negedge clk);
		$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [15:0] raw_for(logic [15:0] f);
		logic [15:0] a;
		a = 16'($urandom);
		a[15:12] = f[15:12];
		if (!cur_variant) begin
			a[5] = f[5];
			a[4] = f[0];
			a[3] = f[1];
		end else begin
			a[3] = f[0];
			a[4] = f[1];
		end
		return a;
	endfunction

	function automatic logic [15:0] pick_target();
		case ($urandom_range(0, 19))
			0:       return A_PRG0;
			1:       return A_PRG1;
			2:       return A_PRG2;
			3:       return A_SNDSEL;
			4:       return A_SNDDAT;
			5:       return A_CHR0;
			6:       return A_CHR1;
			7:       return A_CHR2;
			8:       return A_CHR3;
			9:       return A_CHR4;
			10:      return A_CHR5;
			11:      return A_CHR6;
			12:      return A_CHR7;
			13:      return A_MIRR;
			14:      return A_RELOAD;
			15:      return A_CTRL;
			16:      return A_ACK;
			17:      return A_RELOAD;
			18:      return A_CTRL;
			default: return A_ACK;
		endcase
	endfunction

	function automatic in_item_t write_beat(logic [15:0] f, logic [7:0] d);
		in_item_t it;
		it.mode        = MODE_WRITE;
		it.bus_address = raw_for(f);
		it.bus_data    = d;
		return it;
	endfunction

	function automatic in_item_t tick_beat();
		in_item_t it;
		it.mode        = MODE_TICK;
		it.bus_address = 16'($urandom);
		it.bus_data    = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t mixed_beat();
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return tick_beat();
		if (r < 55) begin
			it.mode        = MODE_WRITE;
			it.bus_address = 16'($urandom);
			it.bus_data    = 8'($urandom);
			return it;
		end
		return write_beat(pick_target(), 8'($urandom));
	endfunction

	// reload, enable, a run of cycles, then usually an acknowledge
	function automatic void queue_irq_run();
		logic [7:0] ctrl;
		logic [7:0] rld;
		int         n;
		ctrl = 8'($urandom);
		if ($urandom_range(0, 6) != 0)
			ctrl[1] = 1'b1;
		if (ctrl[2]) begin
			rld = 8'($urandom_range(200, 255));
			n   = $urandom_range(4, 60);
		end else begin
			rld = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF;
			n   = $urandom_range(100, 130);
		end
		plan.push_back(write_beat(A_RELOAD, rld));
		plan.push_back(write_beat(A_CTRL, ctrl));
		repeat (n)
			plan.push_back(($urandom_range(0, 11) == 0) ? mixed_beat() : tick_beat());
		if ($urandom_range(0, 4) < 3)
			plan.push_back(write_beat(A_ACK, 8'($urandom)));
	endfunction

	function automatic void queue_mixed_run();
		repeat ($urandom_range(5, 25))
			plan.push_back(mixed_beat());
	endfunction

	task automatic send_beat(in_item_t it);
		if (!quiet && $urandom_range(0, 11) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_plan();
		while (plan.size() > 0)
			send_beat(plan.pop_front());
	endtask

	task automatic run_random(int budget);
		int done;
		done = 0;
		while (done < budget) begin
			if ($urandom_range(0, 1))
				queue_irq_run();
			else
				queue_mixed_run();
			while (plan.size() > 0 && done < budget) begin
				send_beat(plan.pop_front());
				done++;
			end
			plan.delete();
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (sb.outstanding() > 0) @(negedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_board(bit v, logic [7:0] prg, logic [7:0] chr);
		drain();
		repeat (4) @(negedge clk);
		write_cfg(CFG_VARIANT, {7'($urandom), v});
		write_cfg(CFG_PRG_LIMIT, prg);
		write_cfg(CFG_CHR_LIMIT, chr);
		cfg_we <= 1'b0;
		cur_variant = v;
	endtask

	initial begin
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		quiet       = 1'b0;
		hold_req    = 1'b0;
		cur_variant = 1'b0;
		beats_sent  = 0;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: every register, masking above the limit, one overflow
		set_board(1'b0, 8'h3C, 8'h7F);
		plan.push_back(write_beat(A_PRG0, 8'hFF));
		plan.push_back(write_beat(A_PRG1, 8'h00));
		plan.push_back(write_beat(A_PRG2, 8'h3C));
		plan.push_back(write_beat(A_SNDSEL, 8'h5A));
		plan.push_back(write_beat(A_SNDDAT, 8'hA5));
		plan.push_back(write_beat(A_CHR0, 8'hFF));
		plan.push_back(write_beat(A_CHR1, 8'h00));
		plan.push_back(write_beat(A_CHR2, 8'h80));
		plan.push_back(write_beat(A_CHR3, 8'h7F));
		plan.push_back(write_beat(A_CHR4, 8'h81));
		plan.push_back(write_beat(A_CHR5, 8'h01));
		plan.push_back(write_beat(A_CHR6, 8'hFE));
		plan.push_back(write_beat(A_CHR7, 8'h40));
		plan.push_back(write_beat(A_MIRR, 8'hFF));
		plan.push_back(write_beat(A_RELOAD, 8'hFE));
		plan.push_back(write_beat(A_CTRL, 8'h07));
		repeat (3) plan.push_back(tick_beat());
		plan.push_back(write_beat(A_ACK, 8'h00));
		plan.push_back(tick_beat());
		plan.push_back(in_item_t'{MODE_WRITE, 16'h0000, 8'hFF});
		plan.push_back(in_item_t'{MODE_WRITE, 16'hFFFF, 8'h00});
		plan.push_back(write_beat(A_CTRL, 8'h00));
		plan.push_back(in_item_t'{MODE_TICK, 16'hFFFF, 8'hFF});
		send_plan();
		run_random(RUN_BEATS);

		set_board(1'b1, 8'h00, 8'h00);
		hold_req = 1'b1;
		run_random(RUN_BEATS);

		set_board(1'b0, 8'hFF, 8'hFF);
		run_random(RUN_BEATS / 2);
		drain();
		run_random(RUN_BEATS / 2);

		set_board(1'b1, 8'($urandom), 8'($urandom));
		run_random(RUN_BEATS);

		set_board(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
		quiet = 1'b1;
		run_random(RUN_BEATS);

		drain();
		repeat (8) @(negedge clk);
		$display("%0d beats driven across five board settings, %0d results checked, %0d with IRQ high",
			beats_sent, sb.checked, sb.irq_high);
		$display("%0d field mismatches, %0d results with nothing expected, %0d still expected",
			sb.mismatches, sb.strays, sb.outstanding());
		if (sb.mismatches == 0 && sb.strays == 0 && sb.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
sv/mbic_pkg.sv
sv/mbic_decode.sv
sv/mbic_state.sv
sv/mapper_bank_and_irq_controller.sv
sv/mbic_checker.sv
dv/mapper_shadow_pkg.sv
dv/tb_top.sv
